>>> src/srecord_s1_section_writer_assert.svh
// Assertion macros shared by the checker file of the S1 section writer.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SRECORD_S1_SECTION_WRITER_ASSERT_SVH
`define SRECORD_S1_SECTION_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRS1_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srecord S1 writer check failed");

// Next-cycle implication, checked outside reset.
`define SRS1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srecord S1 writer check failed");

`endif

>>> src/srs1_pkg.sv
// Package of the S1 section writer: transaction types, microcode types and the
// microcode program. Depends on nothing.
package srs1_pkg;

    localparam int NUM_SECTIONS_DEF   = 10;
    localparam int MAX_DATA_BYTES_DEF = 26;
    localparam int SECTION_W          = 4;
    localparam int ADDR_W             = 16;
    localparam int COUNT_W            = 5;
    localparam int CHAR_W             = 7;

    localparam logic              CMD_FLUSH = 1'b1;
    localparam logic [CHAR_W-1:0] CHAR_S    = 7'h53;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 7'h31;
    localparam logic [CHAR_W-1:0] CHAR_LF   = 7'h0A;

    typedef struct packed {
        logic                 cmd;
        logic [SECTION_W-1:0] section;
        logic [ADDR_W-1:0]    load_address;
        logic [7:0]           data_byte;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    text_char;
        logic [SECTION_W-1:0] section_out;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_STORE, ST_E_S, ST_E_ONE, ST_E_CNT_HI, ST_E_CNT_LO,
        ST_E_A3, ST_E_A2, ST_E_A1, ST_E_A0, ST_E_D_HI, ST_E_D_LO, ST_E_K_HI,
        ST_E_K_LO, ST_E_NL
    } step_t;

    typedef enum logic [3:0] {
        SRC_S, SRC_ONE, SRC_NL, SRC_CNT_HI, SRC_CNT_LO, SRC_A3, SRC_A2, SRC_A1,
        SRC_A0, SRC_D_HI, SRC_D_LO, SRC_K_HI, SRC_K_LO
    } src_t;

    typedef enum logic [2:0] {
        SUM_NONE, SUM_INIT, SUM_ADD_AHI, SUM_ADD_ALO, SUM_ADD_DATA
    } sum_op_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_STORE, ACT_RD_FIRST, ACT_RD_NEXT, ACT_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        J_NEXT, J_WAIT, J_DISPATCH, J_FULL, J_LOOP, J_END
    } jmp_t;

    typedef struct packed {
        logic    emit;
        src_t    src;
        sum_op_t sum_op;
        act_t    act;
        jmp_t    jmp;
        step_t   target;
    } ucode_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 4'd10)
            c = 7'h30 + CHAR_W'(v);
        else
            c = 7'h41 + CHAR_W'(v - 4'd10);
        return c;
    endfunction

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t u;
        u = '{emit: 1'b0, src: SRC_S, sum_op: SUM_NONE, act: ACT_NONE,
              jmp: J_NEXT, target: ST_IDLE};
        case (s)
            ST_IDLE:     begin u.jmp = J_WAIT; u.target = ST_DISPATCH; end
            ST_DISPATCH: begin u.jmp = J_DISPATCH; u.target = ST_E_S; end
            ST_STORE:    begin u.act = ACT_STORE; u.jmp = J_FULL; u.target = ST_E_S; end
            ST_E_S:      begin u.emit = 1'b1; u.src = SRC_S; u.sum_op = SUM_INIT; end
            ST_E_ONE:    begin u.emit = 1'b1; u.src = SRC_ONE; end
            ST_E_CNT_HI: begin u.emit = 1'b1; u.src = SRC_CNT_HI; end
            ST_E_CNT_LO: begin u.emit = 1'b1; u.src = SRC_CNT_LO; end
            ST_E_A3:     begin u.emit = 1'b1; u.src = SRC_A3; end
            ST_E_A2:     begin u.emit = 1'b1; u.src = SRC_A2; u.sum_op = SUM_ADD_AHI; end
            ST_E_A1:     begin u.emit = 1'b1; u.src = SRC_A1; end
            ST_E_A0:
            begin
                u.emit = 1'b1; u.src = SRC_A0; u.sum_op = SUM_ADD_ALO;
                u.act = ACT_RD_FIRST;
            end
            ST_E_D_HI:   begin u.emit = 1'b1; u.src = SRC_D_HI; end
            ST_E_D_LO:
            begin
                u.emit = 1'b1; u.src = SRC_D_LO; u.sum_op = SUM_ADD_DATA;
                u.act = ACT_RD_NEXT; u.jmp = J_LOOP; u.target = ST_E_D_HI;
            end
            ST_E_K_HI:   begin u.emit = 1'b1; u.src = SRC_K_HI; end
            ST_E_K_LO:   begin u.emit = 1'b1; u.src = SRC_K_LO; end
            ST_E_NL:
            begin
                u.emit = 1'b1; u.src = SRC_NL; u.act = ACT_CLEAR;
                u.jmp = J_END; u.target = ST_STORE;
            end
            default:     begin u.jmp = J_NEXT; u.target = ST_IDLE; end
        endcase
        return u;
    endfunction

endpackage

>>> src/srecord_s1_section_writer.sv
// Top level of the S1 section writer: microcoded sequencer, per-section state
// and output register. Depends on srs1_pkg and srs1_ram.
//
// Usage: the in channel (in_valid/in_ready/in_item) carries one command per
// transaction: append a data byte at a load address to a section's record
// buffer, or flush that section. The out channel (out_valid/out_ready/
// out_item) carries one ASCII character of an S1 record per transaction;
// last marks the newline that closes a record.
// One command is handled at a time. An append that emits nothing passes through
// the idle step of acceptance, dispatch and store; a flush of an empty buffer or
// a command to an unused section passes through acceptance and dispatch only.
// A record of N data bytes has 11 + 2*N characters, 63 for a full record: the
// sequencer emits one character per cycle unless the receiver stalls, and the
// data loop fetches the next byte from the buffer RAM while the low digit of the
// current one goes out. If the receiver stalls, the sequencer waits on the output
// register and resumes without loss. Reset empties every section's buffer and
// leaves the out channel empty; the buffer RAM itself needs no clearing.
module srecord_s1_section_writer
    import srs1_pkg::*;
#(
    parameter int NUM_SECTIONS   = NUM_SECTIONS_DEF,
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int SEC_IW    = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int RAM_DEPTH = NUM_SECTIONS * MAX_DATA_BYTES;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    step_t                step_reg, step_next;
    in_item_t             item_reg, item_next;
    logic                 stored_reg, stored_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]           sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic [COUNT_W-1:0]   byte_count_reg [NUM_SECTIONS];
    logic [COUNT_W-1:0]   byte_count_next [NUM_SECTIONS];
    logic [ADDR_W-1:0]    record_start_reg [NUM_SECTIONS];
    logic [ADDR_W-1:0]    record_start_next [NUM_SECTIONS];
    logic [ADDR_W-1:0]    next_address_reg [NUM_SECTIONS];
    logic [ADDR_W-1:0]    next_address_next [NUM_SECTIONS];

    ucode_t               uc;
    logic                 can_emit;
    logic                 advance;
    logic [SEC_IW-1:0]    sec_idx;
    logic                 in_range;
    logic [COUNT_W-1:0]   cur_cnt;
    logic [ADDR_W-1:0]    cur_start;
    logic [ADDR_W-1:0]    cur_next;
    logic [7:0]           cnt3;
    logic [COUNT_W:0]     idx_plus;
    logic                 more;
    logic                 full;
    logic                 break_rec;
    logic [3:0]           nib;
    logic [CHAR_W-1:0]    ch;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic                 ram_re;
    logic [RAM_AW-1:0]    ram_raddr;
    logic [7:0]           ram_rdata;

    srs1_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        uc        = ucode_rom(step_reg);
        can_emit  = !out_valid_reg || out_ready;
        advance   = !uc.emit || can_emit;
        sec_idx   = item_reg.section[SEC_IW-1:0];
        in_range  = (5'(item_reg.section) < 5'(NUM_SECTIONS));
        cur_cnt   = byte_count_reg[sec_idx];
        cur_start = record_start_reg[sec_idx];
        cur_next  = next_address_reg[sec_idx];
        cnt3      = 8'(cur_cnt) + 8'd3;
        idx_plus  = (COUNT_W + 1)'(idx_reg) + 1'b1;
        more      = idx_plus < (COUNT_W + 1)'(cur_cnt);
        full      = ((COUNT_W + 1)'(cur_cnt) + 1'b1) >= (COUNT_W + 1)'(MAX_DATA_BYTES);
        break_rec = (cur_cnt != '0) && (cur_next != item_reg.load_address);

        case (uc.src)
            SRC_CNT_HI: nib = cnt3[7:4];
            SRC_CNT_LO: nib = cnt3[3:0];
            SRC_A3:     nib = cur_start[15:12];
            SRC_A2:     nib = cur_start[11:8];
            SRC_A1:     nib = cur_start[7:4];
            SRC_A0:     nib = cur_start[3:0];
            SRC_D_HI:   nib = ram_rdata[7:4];
            SRC_D_LO:   nib = ram_rdata[3:0];
            SRC_K_HI:   nib = ~sum_reg[7:4];
            SRC_K_LO:   nib = ~sum_reg[3:0];
            default:    nib = 4'h0;
        endcase

        case (uc.src)
            SRC_S:   ch = CHAR_S;
            SRC_ONE: ch = CHAR_ONE;
            SRC_NL:  ch = CHAR_LF;
            default: ch = hex_char(nib);
        endcase

        step_next         = step_reg;
        item_next         = item_reg;
        stored_next       = stored_reg;
        idx_next          = idx_reg;
        sum_next          = sum_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_item_next     = out_item_reg;
        byte_count_next   = byte_count_reg;
        record_start_next = record_start_reg;
        next_address_next = next_address_reg;
        ram_we            = 1'b0;
        ram_waddr         = RAM_AW'(int'(sec_idx) * MAX_DATA_BYTES + int'(cur_cnt));
        ram_re            = 1'b0;
        ram_raddr         = RAM_AW'(int'(sec_idx) * MAX_DATA_BYTES);

        if (in_valid && in_ready)
        begin
            item_next   = in_item;
            stored_next = 1'b0;
        end

        if (advance)
        begin
            if (uc.emit)
            begin
                out_valid_next            = 1'b1;
                out_item_next.text_char   = ch;
                out_item_next.section_out = item_reg.section;
                out_item_next.last        = (uc.src == SRC_NL);
            end

            case (uc.sum_op)
                SUM_INIT:     sum_next = cnt3;
                SUM_ADD_AHI:  sum_next = sum_reg + cur_start[15:8];
                SUM_ADD_ALO:  sum_next = sum_reg + cur_start[7:0];
                SUM_ADD_DATA: sum_next = sum_reg + ram_rdata;
                default:      sum_next = sum_reg;
            endcase

            case (uc.act)
                ACT_STORE:
                begin
                    ram_we                     = 1'b1;
                    byte_count_next[sec_idx]   = cur_cnt + 1'b1;
                    next_address_next[sec_idx] = item_reg.load_address + 1'b1;
                    stored_next                = 1'b1;
                    if (cur_cnt == '0)
                        record_start_next[sec_idx] = item_reg.load_address;
                end
                ACT_RD_FIRST:
                begin
                    idx_next = '0;
                    ram_re   = 1'b1;
                end
                ACT_RD_NEXT:
                begin
                    idx_next  = idx_plus[COUNT_W-1:0];
                    ram_re    = more;
                    ram_raddr = RAM_AW'(int'(sec_idx) * MAX_DATA_BYTES + int'(idx_plus));
                end
                ACT_CLEAR: byte_count_next[sec_idx] = '0;
                default:   ;
            endcase

            case (uc.jmp)
                J_NEXT: step_next = step_t'(step_reg + 1'b1);
                J_WAIT:
                begin
                    if (in_valid)
                        step_next = uc.target;
                end
                J_DISPATCH:
                begin
                    if (!in_range)
                        step_next = ST_IDLE;
                    else if (item_reg.cmd == CMD_FLUSH)
                        step_next = (cur_cnt != '0) ? uc.target : ST_IDLE;
                    else
                        step_next = break_rec ? uc.target : ST_STORE;
                end
                J_FULL: step_next = full ? uc.target : ST_IDLE;
                J_LOOP: step_next = more ? uc.target : step_t'(step_reg + 1'b1);
                J_END:
                begin
                    if (stored_reg || item_reg.cmd == CMD_FLUSH)
                        step_next = ST_IDLE;
                    else
                        step_next = uc.target;
                end
                default: step_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IDLE;
            out_valid_reg <= 1'b0;
            stored_reg    <= 1'b0;
            for (int i = 0; i < NUM_SECTIONS; i++)
            begin
                byte_count_reg[i]   <= '0;
                record_start_reg[i] <= '0;
                next_address_reg[i] <= '0;
            end
        end
        else
        begin
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            stored_reg       <= stored_next;
            byte_count_reg   <= byte_count_next;
            record_start_reg <= record_start_next;
            next_address_reg <= next_address_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        out_item_reg <= out_item_next;
    end

    assign in_ready  = (step_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> src/srs1_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srs1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 260,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/srs1_checker.sv
// Port-level checker of the S1 section writer and its bind to the top level.
// Depends on srs1_pkg and srecord_s1_section_writer_assert.svh.
`include "srecord_s1_section_writer_assert.svh"

module srs1_checker
    import srs1_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A stalled output transaction holds.
    `SRS1_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // Commands are taken one at a time.
    `SRS1_ASSERT_NEXT(a_one_cmd, in_valid && in_ready, !in_ready)

    // While waiting for a command, only a record's closing newline may be pending.
    `SRS1_ASSERT_NOW(a_idle_out, in_ready && out_valid, out_item.last)

    // The end-of-record mark sits on the newline.
    `SRS1_ASSERT_NOW(a_last_lf, out_valid && out_item.last, out_item.text_char == CHAR_LF)

endmodule

bind srecord_s1_section_writer srs1_checker u_srs1_checker (.*);
